// ===== hw/rtl/pwt_pkg.sv =====
// shared types, codes and constants for the protobuf wire tokenizer
`default_nettype none

package pwt_pkg;

  // default width of the held payload length
  localparam int LENGTH_BITS_DEF = 32;

  // result queue depth, a power of two
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = RQ_PTR_W + 1;

  // result kinds
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // wire types that carry a field
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  // longest varint, counted from zero
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic        last_result;
  } result_t;

  // bit position of varint group idx (7 bits per group)
  function automatic logic [5:0] varint_shift(input logic [3:0] idx);
    logic [5:0] sh;
    case (idx)
      4'd0:    sh = 6'd0;
      4'd1:    sh = 6'd7;
      4'd2:    sh = 6'd14;
      4'd3:    sh = 6'd21;
      4'd4:    sh = 6'd28;
      4'd5:    sh = 6'd35;
      4'd6:    sh = 6'd42;
      4'd7:    sh = 6'd49;
      4'd8:    sh = 6'd56;
      4'd9:    sh = 6'd63;
      default: sh = 6'd0;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pwt_if.sv =====
// valid/ready stream interfaces for message bytes and tokenizer results
`default_nettype none

interface pwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface pwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] field_id;
  logic [2:0]  wire_kind;
  logic [63:0] field_value;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output kind, output field_id, output wire_kind,
                  output field_value, output payload_byte, output status,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input field_id, input wire_kind,
                  input field_value, input payload_byte, input status,
                  input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pwt_decode.sv =====
// wire format state machine: one byte per strobe, up to two results
`default_nettype none

module pwt_decode #(
  parameter int LENGTH_BITS = pwt_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            final_byte,
  output pwt_pkg::result_t     res0,
  output pwt_pkg::result_t     res1,
  output logic [1:0]           res_cnt
);

  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIX64   = 3'd2;
  localparam logic [2:0] PH_FIX32   = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  localparam logic [63:0] MAXLEN = {64{1'b1}} >> (64 - LENGTH_BITS);

  logic [2:0]             phase_r, phase_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [3:0]             idx_r, idx_nxt;
  logic [31:0]            field_r, field_nxt;
  logic [2:0]             wire_r, wire_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   err_seen_r, err_seen_nxt;

  logic [63:0]            vacc;
  logic [63:0]            facc;
  logic [3:0]             idx_inc;
  logic [3:0]             fix_need;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   len_sat;
  logic                   err;
  logic                   tok;
  pwt_pkg::result_t       tok_res;
  pwt_pkg::result_t       end_res;

  assign vacc     = acc_r | ({57'b0, data_byte[6:0]} << pwt_pkg::varint_shift(idx_r));
  assign facc     = acc_r | ({56'b0, data_byte} << {idx_r[2:0], 3'b000});
  assign idx_inc  = idx_r + 4'd1;
  assign fix_need = (phase_r == PH_FIX64) ? 4'd8 : 4'd4;
  assign rem_dec  = rem_r - LENGTH_BITS'(1);
  assign len_sat  = vacc > MAXLEN;

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    field_nxt    = field_r;
    wire_nxt     = wire_r;
    rem_nxt      = rem_r;
    err_seen_nxt = err_seen_r;
    err          = 1'b0;
    tok          = 1'b0;
    tok_res              = '0;
    tok_res.field_id     = field_r;
    tok_res.wire_kind    = wire_r;
    tok_res.last_result  = !final_byte;
    end_res              = '0;
    end_res.kind         = pwt_pkg::KIND_END;
    end_res.last_result  = 1'b1;

    case (phase_r)
      PH_KEY, PH_VARINT, PH_LENGTH: begin
        if (idx_r >= pwt_pkg::VARINT_LAST_IDX && data_byte[7:1] != 7'd0) begin
          err = 1'b1;
        end else if (data_byte[7]) begin
          acc_nxt = vacc;
          idx_nxt = idx_inc;
        end else begin
          acc_nxt = '0;
          idx_nxt = '0;
          if (phase_r == PH_KEY) begin
            // field number must be nonzero and fit in 32 bits
            if (vacc[63:35] != '0 || vacc[34:3] == '0) begin
              err = 1'b1;
            end else begin
              field_nxt = vacc[34:3];
              wire_nxt  = vacc[2:0];
              case (vacc[2:0])
                pwt_pkg::WIRE_VARINT: phase_nxt = PH_VARINT;
                pwt_pkg::WIRE_FIX64:  phase_nxt = PH_FIX64;
                pwt_pkg::WIRE_LEN:    phase_nxt = PH_LENGTH;
                pwt_pkg::WIRE_FIX32:  phase_nxt = PH_FIX32;
                default:              err = 1'b1;
              endcase
            end
          end else if (phase_r == PH_VARINT) begin
            tok               = 1'b1;
            tok_res.kind      = pwt_pkg::KIND_SCALAR;
            tok_res.field_value = vacc;
            phase_nxt         = PH_KEY;
          end else begin
            tok               = 1'b1;
            tok_res.kind      = pwt_pkg::KIND_HEADER;
            tok_res.field_value = len_sat ? MAXLEN : vacc;
            if (vacc == '0) begin
              phase_nxt = PH_KEY;
            end else begin
              rem_nxt   = len_sat ? MAXLEN[LENGTH_BITS-1:0] : vacc[LENGTH_BITS-1:0];
              // index 1 marks a held length that never counts down
              idx_nxt   = {3'b000, len_sat};
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_FIX64, PH_FIX32: begin
        acc_nxt = facc;
        idx_nxt = idx_inc;
        if (idx_inc >= fix_need) begin
          tok                 = 1'b1;
          tok_res.kind        = pwt_pkg::KIND_SCALAR;
          tok_res.field_value = facc;
          acc_nxt             = '0;
          idx_nxt             = '0;
          phase_nxt           = PH_KEY;
        end
      end
      PH_PAYLOAD: begin
        tok                  = 1'b1;
        tok_res.kind         = pwt_pkg::KIND_PAYLOAD;
        tok_res.payload_byte = data_byte;
        if (idx_r == '0) begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_KEY;
          end
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      phase_nxt = PH_ERROR;
      acc_nxt   = '0;
      idx_nxt   = '0;
      if (!final_byte) begin
        err_seen_nxt = 1'b1;
      end
    end

    if (final_byte) begin
      if (err_seen_r) begin
        end_res.status = pwt_pkg::ST_MALFORMED;
      end else if (err || phase_nxt != PH_KEY || idx_nxt != '0) begin
        end_res.status = pwt_pkg::ST_TRUNCATED;
      end else begin
        end_res.status = pwt_pkg::ST_OK;
      end
      phase_nxt    = PH_KEY;
      acc_nxt      = '0;
      idx_nxt      = '0;
      field_nxt    = '0;
      wire_nxt     = '0;
      rem_nxt      = '0;
      err_seen_nxt = 1'b0;
    end
  end

  assign res0    = tok ? tok_res : end_res;
  assign res1    = end_res;
  assign res_cnt = {1'b0, tok} + {1'b0, final_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KEY;
      acc_r      <= '0;
      idx_r      <= '0;
      field_r    <= '0;
      wire_r     <= '0;
      rem_r      <= '0;
      err_seen_r <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      idx_r      <= idx_nxt;
      field_r    <= field_nxt;
      wire_r     <= wire_nxt;
      rem_r      <= rem_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pwt_result_queue.sv =====
// small result queue: takes up to two results a cycle, hands out one
`default_nettype none

module pwt_result_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire pwt_pkg::result_t push0,
  input  wire pwt_pkg::result_t push1,
  output logic                  room,
  output logic                  head_valid,
  input  wire logic             head_ready,
  output pwt_pkg::result_t      head
);

  pwt_pkg::result_t              slot_r [pwt_pkg::RQ_DEPTH];
  logic [pwt_pkg::RQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pwt_pkg::RQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [pwt_pkg::RQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [pwt_pkg::RQ_PTR_W-1:0]  wr_ptr_p1;
  logic                          pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = cnt_r != '0;
  assign head       = slot_r[rd_ptr_r];
  // room for a full request of two results, regardless of this cycle's pop
  assign room       = cnt_r <= pwt_pkg::RQ_CNT_W'(pwt_pkg::RQ_DEPTH - 2);
  assign wr_ptr_p1  = wr_ptr_r + pwt_pkg::RQ_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + pwt_pkg::RQ_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + pwt_pkg::RQ_PTR_W'(pop);
    cnt_nxt    = cnt_r + pwt_pkg::RQ_CNT_W'(push_cnt) - pwt_pkg::RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slot_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/protobuf_wire_tokenizer.sv =====
// top level of the protobuf wire format tokenizer
//
//   port        dir   payload                                      per request
//   in_stream   sink  data_byte, final_byte                        one message byte
//   out_stream  src   kind, field_id, wire_kind, field_value,      one token or
//                     payload_byte, status, last_result            end status
//
// one byte a cycle while the queue has room: a byte sits in the input register, is decoded
// combinationally and its results land in a four-deep result queue that drives out_stream
// a final byte that also closes a field gives two results, both queued for
// out_stream; input stalls only when the queue cannot take two more
// in_stream reaches out_stream through the input register and the result queue
// synchronous reset puts the decoder at the start of a message and empties the queue
`default_nettype none

module protobuf_wire_tokenizer #(
  parameter int LENGTH_BITS = pwt_pkg::LENGTH_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pwt_in_if.sink     in_stream,
  pwt_out_if.source  out_stream
);

  logic             in_hold_r;
  logic [7:0]       in_data_r;
  logic             in_final_r;
  logic             room;
  logic             fire;
  logic [1:0]       res_cnt;
  logic [1:0]       push_cnt;
  pwt_pkg::result_t res0;
  pwt_pkg::result_t res1;
  pwt_pkg::result_t head;

  assign fire            = in_hold_r && room;
  assign in_stream.ready = !in_hold_r || fire;
  assign push_cnt        = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hold_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_hold_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      in_data_r  <= in_stream.data_byte;
      in_final_r <= in_stream.final_byte;
    end
  end

  pwt_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_data_r),
    .final_byte (in_final_r),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt)
  );

  pwt_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .head_valid (out_stream.valid),
    .head_ready (out_stream.ready),
    .head       (head)
  );

  assign out_stream.kind         = head.kind;
  assign out_stream.field_id     = head.field_id;
  assign out_stream.wire_kind    = head.wire_kind;
  assign out_stream.field_value  = head.field_value;
  assign out_stream.payload_byte = head.payload_byte;
  assign out_stream.status       = head.status;
  assign out_stream.last_result  = head.last_result;

endmodule

`default_nettype wire
